[sv/qrr_pkg.sv]
`timescale 1ns / 1ps
package qrr_pkg;

  typedef enum logic [1:0] {
    ST_NEG_DISC  = 2'd0,
    ST_DEGEN     = 2'd1,
    ST_QUADRATIC = 2'd2,
    ST_LINEAR    = 2'd3
  } status_e;

  // How the back end picks numerators and divisors for the two roots.
  typedef enum logic [1:0] {
    K_ZERO   = 2'd0,
    K_LINEAR = 2'd1,
    K_BZERO  = 2'd2,
    K_FULL   = 2'd3
  } kind_e;

endpackage

[sv/qrr_front.sv]
`timescale 1ns / 1ps
// Front end: splits signs and magnitudes, forms the discriminant over
// pipelined multiply stages, then takes its integer square root one result
// bit per stage.
module qrr_front
  import qrr_pkg::*;
#(
  parameter int W = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [W-1:0]   coef_a_i,
  input  logic [W-1:0]   coef_b_i,
  input  logic [W-1:0]   coef_c_i,
  output logic           valid_o,
  input  logic           ready_i,
  output kind_e          kind_o,
  output logic           sa_o,
  output logic           sb_o,
  output logic           sc_o,
  output logic [W:0]     ma_o,
  output logic [W:0]     mb_o,
  output logic [W:0]     mc_o,
  output logic [W+1:0]   root_o
);

  localparam int DW = 2 * W + 4;     // discriminant width
  localparam int RW = DW / 2;        // square root width
  localparam int NS = RW + 3;        // total stages

  typedef struct packed {
    logic         sa, sb, sc;
    logic [W:0]   ma, mb, mc;
    logic         ok;
    logic [DW-1:0] rem;
    logic [RW-1:0] res;
  } st_t;

  st_t         st_q [NS];
  logic [NS-1:0] v_q;
  logic [2*W+1:0] bb_q, ac_q;
  logic        adv;

  assign adv     = !v_q[NS-1] || ready_i;
  assign ready_o = adv;

  function automatic logic [W:0] mag(input logic [W-1:0] v);
    logic [W:0] x;
    x = {v[W-1], v};
    mag = v[W-1] ? (~x + 1'b1) : x;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    st_t           s;
    logic [DW-1:0] cand;
    if (adv) begin
      // stage 0: capture
      s = '0;
      s.sa = coef_a_i[W-1];
      s.sb = coef_b_i[W-1];
      s.sc = coef_c_i[W-1];
      s.ma = mag(coef_a_i);
      s.mb = mag(coef_b_i);
      s.mc = mag(coef_c_i);
      st_q[0] <= s;
      // stage 1: products
      st_q[1] <= st_q[0];
      bb_q <= (2*W+2)'(st_q[0].mb) * (2*W+2)'(st_q[0].mb);
      ac_q <= (2*W+2)'(st_q[0].ma) * (2*W+2)'(st_q[0].mc);
      // stage 2: discriminant
      s = st_q[1];
      if (st_q[1].sa != st_q[1].sc) begin
        s.rem = DW'(bb_q) + {ac_q, 2'b00};
        s.ok  = 1'b1;
      end else begin
        s.rem = DW'(bb_q) - {ac_q, 2'b00};
        s.ok  = DW'(bb_q) >= {ac_q, 2'b00};
      end
      st_q[2] <= s;
      // restoring square root, one result bit per stage
      for (int k = 0; k < RW; k++) begin
        s = st_q[k+2];
        cand = (({(DW-RW)'(0), s.res} << 2) | DW'(1)) << (2 * (RW - 1 - k));
        if (s.rem >= cand) begin
          s.rem = s.rem - cand;
          s.res = {s.res[RW-2:0], 1'b1};
        end else begin
          s.res = {s.res[RW-2:0], 1'b0};
        end
        st_q[k+3] <= s;
      end
    end
  end

  always_comb begin
    st_t o;
    o = st_q[NS-1];
    valid_o = v_q[NS-1];
    sa_o = o.sa;
    sb_o = o.sb;
    sc_o = o.sc;
    ma_o = o.ma;
    mb_o = o.mb;
    mc_o = o.mc;
    root_o = (W+2)'(o.res);
    if (o.ma != '0) begin
      if (!o.ok) kind_o = K_ZERO;
      else if (o.mb == '0) kind_o = K_BZERO;
      else kind_o = K_FULL;
    end else if (o.mb != '0) begin
      kind_o = K_LINEAR;
    end else begin
      kind_o = K_ZERO;
    end
  end

endmodule

[sv/qrr_fifo.sv]
`timescale 1ns / 1ps
// Short queue between the front and back ends.
module qrr_fifo #(
  parameter int DW = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [DW-1:0] data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [DW-1:0] data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          push, pop;

  assign ready_o = cnt_q != (AW+1)'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end

endmodule

[sv/qrr_back.sv]
`timescale 1ns / 1ps
// Back end: two pipelined restoring dividers, one quotient bit per stage,
// followed by sign and saturation.
module qrr_back
  import qrr_pkg::*;
#(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  kind_e        kind_i,
  input  logic         sa_i,
  input  logic         sb_i,
  input  logic         sc_i,
  input  logic [W:0]   ma_i,
  input  logic [W:0]   mb_i,
  input  logic [W:0]   mc_i,
  input  logic [W+1:0] root_i,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [1:0]   status_o,
  output logic [W-1:0] root_one_o,
  output logic [W-1:0] root_two_o,
  output logic         saturated_o
);

  localparam int NW = W + 3 + F;   // numerator width
  localparam int DV = W + 3;       // divisor width
  localparam int QW = NW;          // quotient width
  localparam int NS = QW + 2;

  typedef struct packed {
    logic [1:0]   status;
    logic         n1, n2;
    logic [NW-1:0] num1, num2;
    logic [DV-1:0] den1, den2;
    logic [DV:0]   rem1, rem2;
    logic [QW-1:0] q1, q2;
  } st_t;

  st_t st_q [NS];
  logic [NS-1:0] v_q;
  logic adv;
  st_t s0;

  assign adv     = !v_q[NS-1] || ready_i;
  assign ready_o = adv;

  always_comb begin
    logic [DV-1:0] qv, a2;
    s0 = '0;
    qv = DV'(mb_i) + DV'(root_i);
    a2 = DV'({ma_i, 1'b0});
    unique case (kind_i)
      K_LINEAR: begin
        s0.status = ST_LINEAR;
        s0.num1 = NW'(mc_i) << F;  s0.den1 = DV'(mb_i);  s0.n1 = sc_i == sb_i;
        s0.num2 = NW'(mc_i) << F;  s0.den2 = DV'(mb_i);  s0.n2 = sc_i == sb_i;
      end
      K_BZERO: begin
        s0.status = ST_QUADRATIC;
        s0.num1 = NW'(root_i) << F;  s0.den1 = a2;  s0.n1 = sa_i;
        s0.num2 = NW'(root_i) << F;  s0.den2 = a2;  s0.n2 = !sa_i;
      end
      K_FULL: begin
        s0.status = ST_QUADRATIC;
        if (!sb_i) begin
          s0.num1 = NW'({mc_i, 1'b0}) << F;  s0.den1 = qv;  s0.n1 = !sc_i;
          s0.num2 = NW'(qv) << F;            s0.den2 = a2;  s0.n2 = !sa_i;
        end else begin
          s0.num1 = NW'(qv) << F;            s0.den1 = a2;  s0.n1 = sa_i;
          s0.num2 = NW'({mc_i, 1'b0}) << F;  s0.den2 = qv;  s0.n2 = sc_i;
        end
      end
      default: begin
        s0.status = (ma_i != '0) ? ST_NEG_DISC : ST_DEGEN;
        s0.den1 = DV'(1);
        s0.den2 = DV'(1);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  function automatic logic [W:0] fin(input logic [QW-1:0] q, input logic n);
    logic [QW-1:0] lim;
    logic [W-1:0]  m;
    logic          s;
    lim = n ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - 1'b1);
    s = q > lim;
    m = s ? lim[W-1:0] : q[W-1:0];
    if (n) m = ~m + 1'b1;
    fin = {s, m};
  endfunction

  always_ff @(posedge clk_i) begin
    st_t         s;
    logic [DV:0] t1, t2;
    logic [W:0]  f1, f2;
    if (adv) begin
      st_q[0] <= s0;
      // one quotient bit per stage for each divider
      for (int k = 0; k < QW; k++) begin
        s = st_q[k];
        t1 = {s.rem1[DV-1:0], s.num1[NW-1-k]};
        t2 = {s.rem2[DV-1:0], s.num2[NW-1-k]};
        if (t1 >= {1'b0, s.den1}) begin
          s.rem1 = t1 - {1'b0, s.den1};
          s.q1 = {s.q1[QW-2:0], 1'b1};
        end else begin
          s.rem1 = t1;
          s.q1 = {s.q1[QW-2:0], 1'b0};
        end
        if (t2 >= {1'b0, s.den2}) begin
          s.rem2 = t2 - {1'b0, s.den2};
          s.q2 = {s.q2[QW-2:0], 1'b1};
        end else begin
          s.rem2 = t2;
          s.q2 = {s.q2[QW-2:0], 1'b0};
        end
        st_q[k+1] <= s;
      end
      st_q[NS-1] <= st_q[QW];
      f1 = fin(st_q[QW].q1, st_q[QW].n1);
      f2 = fin(st_q[QW].q2, st_q[QW].n2);
      if (st_q[QW].status == ST_QUADRATIC || st_q[QW].status == ST_LINEAR) begin
        root_one_o  <= f1[W-1:0];
        root_two_o  <= f2[W-1:0];
        saturated_o <= f1[W] | f2[W];
      end else begin
        root_one_o  <= '0;
        root_two_o  <= '0;
        saturated_o <= 1'b0;
      end
    end
  end

  assign valid_o  = v_q[NS-1];
  assign status_o = st_q[NS-1].status;

endmodule

[sv/quadratic_real_roots_unit.sv]
`timescale 1ns / 1ps
// Order: square root bit stages, then the two-entry queue, then divider
// quotient bit stages.
// Throughput: one item per cycle when out_ready_i does not stall it; both the
// square root and the dividers are fully pipelined, one result bit per stage.
// Reset: rst_ni clears all valid flags and the queue pointers; no clearing pass.
module quadratic_real_roots_unit
  import qrr_pkg::*;
#(
  parameter int COEF_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COEF_WIDTH-1:0] coef_a_i,
  input  logic [COEF_WIDTH-1:0] coef_b_i,
  input  logic [COEF_WIDTH-1:0] coef_c_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [COEF_WIDTH-1:0] root_one_o,
  output logic [COEF_WIDTH-1:0] root_two_o,
  output logic                  saturated_o
);

  localparam int W  = COEF_WIDTH;
  localparam int QD = 2 + 3 + 3 * (W + 1) + (W + 2);

  logic         fv, fr, qv, qr;
  kind_e        fk;
  logic         fsa, fsb, fsc;
  logic [W:0]   fma, fmb, fmc;
  logic [W+1:0] froot;
  logic [QD-1:0] qin, qout;

  qrr_front #(.W(W)) u_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o),
    .coef_a_i, .coef_b_i, .coef_c_i,
    .valid_o(fv), .ready_i(fr),
    .kind_o(fk), .sa_o(fsa), .sb_o(fsb), .sc_o(fsc),
    .ma_o(fma), .mb_o(fmb), .mc_o(fmc), .root_o(froot)
  );

  assign qin = {fk, fsa, fsb, fsc, fma, fmb, fmc, froot};

  qrr_fifo #(.DW(QD), .DEPTH(2)) u_fifo (
    .clk_i, .rst_ni,
    .valid_i(fv), .ready_o(fr), .data_i(qin),
    .valid_o(qv), .ready_i(qr), .data_o(qout)
  );

  qrr_back #(.W(W), .F(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .valid_i(qv), .ready_o(qr),
    .kind_i(kind_e'(qout[QD-1 -: 2])),
    .sa_i(qout[QD-3]), .sb_i(qout[QD-4]), .sc_i(qout[QD-5]),
    .ma_i(qout[3*(W+1)+W+1 -: W+1]),
    .mb_i(qout[2*(W+1)+W+1 -: W+1]),
    .mc_i(qout[(W+1)+W+1 -: W+1]),
    .root_i(qout[W+1:0]),
    .valid_o(out_valid_o), .ready_i(out_ready_i),
    .status_o, .root_one_o, .root_two_o, .saturated_o
  );

endmodule
